@@ src/wpm_pkg.sv @@
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Shared sizes, action codes, pattern symbols and interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  localparam int unsigned MaxPattern = 32;
  localparam int unsigned LenW       = $clog2(MaxPattern + 1);

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_TEXT   = 2'd2;
  localparam logic [1:0] ACT_END    = 2'd3;

  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_ANY  = 8'h3F;

  typedef struct packed {
    logic clear;
    logic step;
    logic restart;
  } wpm_ctrl_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } wpm_res_t;

endpackage

`default_nettype wire

@@ src/wpm_cell.sv @@
// ----------------------------------------------------------------------------
// Wildcard pattern matcher cell
// Holds one pattern byte with its start and prefix flags and forms the
// generate and propagate terms of the star closure.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wpm_pkg::wpm_ctrl_t ctrl_i,
  input  wire logic              load_i,
  input  wire logic              active_i,
  input  wire logic [7:0]        symbol_i,
  input  wire logic              start_prev_i,
  input  wire logic              prefix_prev_i,
  input  wire logic              next_i,
  output logic                   start_o,
  output logic                   prefix_o,
  output logic                   gen_o,
  output logic                   prop_o
);
  import wpm_pkg::*;

  logic [7:0] pat_q;
  logic       start_q, start_d;
  logic       prefix_q, prefix_d;
  logic       is_star;
  logic       hit;

  assign is_star = (pat_q == SYM_STAR);
  assign hit     = (pat_q == symbol_i) || (pat_q == SYM_ANY) || is_star;
  assign gen_o   = active_i & ((prefix_prev_i & hit) | (is_star & prefix_q));
  assign prop_o  = active_i & is_star;

  always_comb begin
    start_d = start_q;
    if (ctrl_i.clear) begin
      start_d = 1'b0;
    end else if (load_i) begin
      start_d = (symbol_i == SYM_STAR) & start_prev_i;
    end
  end

  always_comb begin
    prefix_d = prefix_q;
    if (ctrl_i.step) begin
      prefix_d = next_i;
    end else if (ctrl_i.restart) begin
      prefix_d = start_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= 1'b0;
      prefix_q <= 1'b0;
    end else begin
      start_q  <= start_d;
      prefix_q <= prefix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= symbol_i;
    end
  end

  assign start_o  = start_q;
  assign prefix_o = prefix_q;

endmodule

`default_nettype wire

@@ src/wpm_out_skid.sv @@
// ----------------------------------------------------------------------------
// Wildcard pattern matcher output stage
// Output register with a skid entry so that the input side keeps moving
// while a result word waits.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_out_skid (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             res_valid_i,
  input  wire wpm_pkg::wpm_res_t res_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output wpm_pkg::wpm_res_t     out_o
);
  import wpm_pkg::*;

  logic     out_valid_q;
  logic     skid_valid_q;
  wpm_res_t out_q;
  wpm_res_t skid_q;
  logic     out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | res_valid_i;
      skid_valid_q <= 1'b0;
    end else if (res_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (res_valid_i) begin
      skid_q <= res_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

@@ src/wildcard_pattern_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// Wildcard pattern matcher unit
// Matches streamed text against a stored pattern with '?' and '*' wildcards
// using a row of pattern cells that share a bit vector of matched prefixes.
//
//   Channel  Direction  Handshake                Fields
//   in       input      in_valid_i / in_stall_o  action_i, symbol_i
//   out      output     out_valid_o / out_stall_i matched_o, pattern_overflow_o
//
// A new word is accepted in every cycle unless the input stalls.
// A result word is registered in the output register, or first in the skid entry while the output stalls.
// The star closure across all cells is one carry chain of 33 bits.
// Reset leaves an empty pattern and no overflow.
// The input stalls only when a result waits and the skid entry is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_matcher_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] symbol_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            matched_o,
  output logic            pattern_overflow_o
);
  import wpm_pkg::*;

  logic                  in_accept;
  logic                  pat_full;
  logic                  do_append;
  logic [LenW-1:0]       length_q;
  logic                  ovf_q;
  logic                  prefix0_q;
  wpm_ctrl_t             ctrl;
  logic [MaxPattern-1:0] load;
  logic [MaxPattern-1:0] active;
  logic [MaxPattern-1:0] start_bits;
  logic [MaxPattern-1:0] prefix_bits;
  logic [MaxPattern-1:0] gen;
  logic [MaxPattern-1:0] prop;
  logic [MaxPattern:0]   add_a;
  logic [MaxPattern:0]   add_b;
  logic [MaxPattern:0]   add_s;
  logic [MaxPattern:0]   carry;
  logic [MaxPattern:0]   prefix_vec;
  logic                  res_valid;
  wpm_res_t              res;
  wpm_res_t              out_res;

  assign in_accept = in_valid_i && !in_stall_o;
  assign pat_full  = (length_q == LenW'(MaxPattern));
  assign do_append = in_accept && (action_i == ACT_APPEND) && !pat_full;

  assign ctrl.clear   = in_accept && (action_i == ACT_CLEAR);
  assign ctrl.step    = in_accept && (action_i == ACT_TEXT);
  assign ctrl.restart = in_accept && (action_i != ACT_TEXT);

  // Star closure: next[k] = gen[k] | star[k] & next[k-1], run as a carry chain.
  assign add_a = {1'b0, gen | prop};
  assign add_b = {1'b0, gen};
  assign add_s = add_a + add_b;
  assign carry = add_s ^ add_a ^ add_b;

  genvar gi;
  generate
    for (gi = 0; gi < MaxPattern; gi++) begin : g_cell
      assign load[gi]   = do_append && (length_q == LenW'(gi));
      assign active[gi] = (LenW'(gi) < length_q);

      wpm_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctrl_i        (ctrl),
        .load_i        (load[gi]),
        .active_i      (active[gi]),
        .symbol_i      (symbol_i),
        .start_prev_i  ((gi == 0) ? 1'b1 : start_bits[(gi == 0) ? 0 : gi - 1]),
        .prefix_prev_i ((gi == 0) ? prefix0_q : prefix_bits[(gi == 0) ? 0 : gi - 1]),
        .next_i        (carry[gi + 1]),
        .start_o       (start_bits[gi]),
        .prefix_o      (prefix_bits[gi]),
        .gen_o         (gen[gi]),
        .prop_o        (prop[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q  <= '0;
      ovf_q     <= 1'b0;
      prefix0_q <= 1'b1;
    end else begin
      if (ctrl.clear) begin
        length_q <= '0;
        ovf_q    <= 1'b0;
      end else if (do_append) begin
        length_q <= length_q + LenW'(1);
      end else if (in_accept && (action_i == ACT_APPEND)) begin
        ovf_q <= 1'b1;
      end
      if (ctrl.step) begin
        prefix0_q <= 1'b0;
      end else if (ctrl.restart) begin
        prefix0_q <= 1'b1;
      end
    end
  end

  assign prefix_vec   = {prefix_bits, prefix0_q};
  assign res_valid    = in_accept && (action_i == ACT_END);
  assign res.matched  = prefix_vec[length_q];
  assign res.overflow = ovf_q;

  wpm_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign matched_o          = out_res.matched;
  assign pattern_overflow_o = out_res.overflow;

  a_prefix_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prefix_bits & ~active) == '0)
    else $error("prefix flag set beyond the pattern length");

  a_start_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_bits & ~active) == '0)
    else $error("start flag set beyond the pattern length");

  a_length_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_q <= LenW'(MaxPattern))
    else $error("pattern length beyond capacity");

  a_result_shown : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_o)
    else $error("end-of-text word gave no result word");

endmodule

`default_nettype wire

@@ bench/wildcard_pattern_matcher_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Wildcard pattern matcher unit testbench
// Streams clear, append, text and end-of-text words into the matcher and
// predicts every result word from its own prefix vector model. A short
// directed run covers empty patterns, empty texts and stars matched against
// stars. Random patterns follow, with texts built to fit them, mutated texts,
// overflowing loads and stray words. The sender idles and the receiver stalls
// at different rates from phase to phase.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_matcher_unit_tb;
  import wpm_pkg::*;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] symbol;
  } word_t;

  localparam int unsigned PhaseWords = 375;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainCycles = 16;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] action_i    = ACT_CLEAR;
  logic [7:0] symbol_i    = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       matched_o;
  logic       pattern_overflow_o;

  wildcard_pattern_matcher_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .symbol_i          (symbol_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .matched_o         (matched_o),
    .pattern_overflow_o(pattern_overflow_o)
  );

  always #6 clk_i = ~clk_i;

  logic [7:0]          pattern_bytes [MaxPattern];
  int unsigned         pattern_len    = 0;
  logic [MaxPattern:0] empty_prefixes = 1;
  logic [MaxPattern:0] live_prefixes  = 1;
  logic                overflow_flag  = 1'b0;
  wpm_res_t            verdict_q[$];
  word_t               word_q[$];
  logic [7:0]          draft_pat[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        calm = 1'b0;
  int unsigned calm_timer = 0;
  int unsigned queued_words = 0;
  int unsigned taken_words = 0;
  int unsigned text_words = 0;
  int unsigned checked_results = 0;
  int unsigned match_results = 0;
  int unsigned overflow_results = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [MaxPattern:0] step_prefixes(logic [7:0] c);
    logic [MaxPattern:0] nxt;
    logic [7:0]          p;
    nxt = '0;
    for (int k = 1; k <= pattern_len; k++) begin
      p = pattern_bytes[k-1];
      nxt[k] = (live_prefixes[k-1] && (p == c || p == SYM_ANY || p == SYM_STAR)) ||
               (p == SYM_STAR && live_prefixes[k]);
    end
    for (int k = 1; k <= pattern_len; k++) begin
      if (pattern_bytes[k-1] == SYM_STAR && nxt[k-1]) begin
        nxt[k] = 1'b1;
      end
    end
    return nxt;
  endfunction

  task automatic track_word(input word_t w);
    wpm_res_t r;
    case (w.action)
      ACT_CLEAR: begin
        pattern_len = 0;
        empty_prefixes = 1;
        overflow_flag = 1'b0;
        live_prefixes = empty_prefixes;
      end
      ACT_APPEND: begin
        if (pattern_len >= MaxPattern) begin
          overflow_flag = 1'b1;
        end else begin
          pattern_bytes[pattern_len] = w.symbol;
          empty_prefixes[pattern_len+1] = (w.symbol == SYM_STAR) &&
                                          empty_prefixes[pattern_len];
          pattern_len++;
        end
        live_prefixes = empty_prefixes;
      end
      ACT_TEXT: begin
        live_prefixes = step_prefixes(w.symbol);
        text_words++;
      end
      default: begin
        r.matched = live_prefixes[pattern_len];
        r.overflow = overflow_flag;
        verdict_q.push_back(r);
        live_prefixes = empty_prefixes;
      end
    endcase
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i) begin : drive_words
    word_t w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        w.action = action_i;
        w.symbol = symbol_i;
        track_word(w);
        taken_words++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (word_q.size() != 0 && (calm || $urandom_range(0, 99) >= send_idle_pct)) begin
          w = word_q.pop_front();
          in_valid_i <= 1'b1;
          action_i <= w.action;
          symbol_i <= w.symbol;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watch_results
    wpm_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        checked_results++;
        if (verdict_q.size() == 0) begin
          report_error($sformatf("result word with none expected: matched=%0b overflow=%0b",
                                 matched_o, pattern_overflow_o));
        end else begin
          want = verdict_q.pop_front();
          if (want.matched) match_results++;
          if (want.overflow) overflow_results++;
          if (matched_o !== want.matched || pattern_overflow_o !== want.overflow) begin
            report_error($sformatf("expected matched=%0b overflow=%0b, got matched=%0b overflow=%0b",
                                   want.matched, want.overflow, matched_o,
                                   pattern_overflow_o));
          end
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < recv_stall_pct);
      if (calm_timer == 0) begin
        calm <= ($urandom_range(0, 3) == 0);
        calm_timer <= $urandom_range(40, 120);
      end else begin
        calm_timer <= calm_timer - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (word_q.size() != 0 || verdict_q.size() != 0 || in_valid_i) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("wildcard_pattern_matcher_unit_tb: errors");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [1:0] a, input logic [7:0] s);
    word_t w;
    w.action = a;
    w.symbol = s;
    word_q.push_back(w);
    queued_words++;
  endtask

  function automatic logic [7:0] pattern_symbol();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return SYM_STAR;
    if (r < 45) return SYM_ANY;
    if (r < 85) return 8'(8'h61 + $urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] text_symbol();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'(8'h61 + $urandom_range(0, 2));
    if (r < 80) return SYM_STAR;
    if (r < 85) return SYM_ANY;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic load_pattern(input int unsigned n);
    logic [7:0] s;
    push_word(ACT_CLEAR, 8'($urandom_range(0, 255)));
    draft_pat.delete();
    for (int i = 0; i < n; i++) begin
      s = pattern_symbol();
      push_word(ACT_APPEND, s);
      if (draft_pat.size() < MaxPattern) draft_pat.push_back(s);
    end
  endtask

  task automatic send_text();
    logic [7:0]  txt[$];
    int unsigned pos;
    foreach (draft_pat[i]) begin
      if (draft_pat[i] == SYM_STAR) begin
        repeat ($urandom_range(0, 3)) txt.push_back(text_symbol());
      end else if (draft_pat[i] == SYM_ANY) begin
        txt.push_back(text_symbol());
      end else begin
        txt.push_back(draft_pat[i]);
      end
    end
    if ($urandom_range(0, 99) < 30) begin
      pos = $urandom_range(0, txt.size());
      case ($urandom_range(0, 2))
        0: txt.insert(pos, text_symbol());
        1: if (pos < txt.size()) txt.delete(pos);
        default: if (pos < txt.size()) txt[pos] = text_symbol();
      endcase
    end
    foreach (txt[i]) push_word(ACT_TEXT, txt[i]);
    push_word(ACT_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_directed();
    push_word(ACT_CLEAR, 8'hFF);
    push_word(ACT_END, 8'h00);
    push_word(ACT_TEXT, 8'h00);
    push_word(ACT_END, 8'hFF);
    push_word(ACT_APPEND, SYM_STAR);
    push_word(ACT_END, 8'h00);
    push_word(ACT_TEXT, SYM_STAR);
    push_word(ACT_TEXT, 8'hFF);
    push_word(ACT_END, 8'h00);
    push_word(ACT_APPEND, SYM_ANY);
    push_word(ACT_TEXT, 8'h00);
    push_word(ACT_APPEND, 8'hFF);
    push_word(ACT_TEXT, 8'h41);
    push_word(ACT_TEXT, 8'hFF);
    push_word(ACT_END, 8'h00);
    push_word(ACT_APPEND, 8'h00);
    push_word(ACT_TEXT, 8'h7E);
    push_word(ACT_TEXT, 8'h80);
    push_word(ACT_TEXT, 8'h00);
    push_word(ACT_END, 8'h00);
    push_word(ACT_CLEAR, 8'h00);
    push_word(ACT_END, 8'hFF);
  endtask

  initial begin
    int unsigned send_pct [4];
    int unsigned stall_pct [4];
    int unsigned phase_start;
    int unsigned r;
    send_pct = '{0, 48, 0, 29};
    stall_pct = '{0, 0, 48, 29};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_stall_pct = stall_pct[ph];
      phase_start = queued_words;
      if (ph == 0) push_directed();
      load_pattern(MaxPattern + $urandom_range(1, 4));
      send_text();
      send_text();
      while (queued_words - phase_start < PhaseWords) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          load_pattern($urandom_range(0, 6));
        end else if (r < 15) begin
          load_pattern($urandom_range(7, MaxPattern));
        end else if (r < 17) begin
          load_pattern(MaxPattern + $urandom_range(1, 3));
        end else if (r < 27) begin
          repeat ($urandom_range(1, 3)) begin
            push_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          end
        end else begin
          send_text();
        end
      end
      while (word_q.size() != 0 || in_valid_i || verdict_q.size() != 0) begin
        @(posedge clk_i);
      end
    end
    repeat (DrainCycles) @(posedge clk_i);
    foreach (verdict_q[i]) begin
      report_error($sformatf("result never arrived: matched=%0b overflow=%0b",
                             verdict_q[i].matched, verdict_q[i].overflow));
    end
    $display("Sent %0d words (%0d text bytes) over four idling phases.",
             taken_words, text_words);
    $display("Checked %0d results: %0d matches, %0d with overflow, %0d errors.",
             checked_results, match_results, overflow_results, error_count);
    if (error_count == 0) begin
      $display("wildcard_pattern_matcher_unit_tb: clean");
    end else begin
      $display("wildcard_pattern_matcher_unit_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
src/wpm_pkg.sv
src/wpm_cell.sv
src/wpm_out_skid.sv
src/wildcard_pattern_matcher_unit.sv
bench/wildcard_pattern_matcher_unit_tb.sv
